/* hdl/afp_pkg.sv */
// ----------------------------------------------------------------------------
// afp_pkg: shared types and constants for the audio frame pacer
// Fixed arithmetic constants, register indexes and the item passed from
// the front pipeline to the accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package afp_pkg;

    // nanoseconds per second
    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

    // floor(2^61 / 1e9): x / 1e9 ~= ((x >> 20) * RECIP) >> 41, low by at most one
    localparam logic [31:0] RECIP       = 32'd2305843009;
    localparam int          RECIP_SHIFT = 41;
    localparam int          HI_SHIFT    = 20;

    localparam int RATE_W   = 18;
    localparam int VAL_W    = 16;
    localparam int NS_W     = 40;
    localparam int SECS_W   = 11;  // 2^40 ns / 1e9 < 2048
    localparam int FRAC_W   = 30;
    localparam int PQ_W     = 18;  // whole frames from the sub-second part
    localparam int BASE_W   = 29;  // secs * rate + sub-second frames
    localparam int PEND_W   = 32;
    localparam int FRAMES_W = 15;
    localparam int SRC_W    = 17;

    localparam logic [RATE_W-1:0] RATE_RESET = 18'd48000;

    // configuration register indexes
    localparam logic [1:0] CFG_SAMPLE_RATE = 2'd0;
    localparam logic [1:0] CFG_TARGET      = 2'd1;
    localparam logic [1:0] CFG_HYSTERESIS  = 2'd2;

    // one pre-processed tick, ready for the accumulator
    typedef struct packed {
        logic [BASE_W-1:0]   base;        // whole frames, before fraction carry
        logic [FRAC_W-1:0]   frac_add;    // leftover numerator, below 1e9
        logic [FRAMES_W-1:0] max_frames;  // max_values / 2
        logic                over;        // buffer above target + hysteresis
        logic                under;       // buffer below target - hysteresis
    } item_t;

endpackage

`default_nettype wire

/* hdl/audio_frame_pacer.sv */
// ----------------------------------------------------------------------------
// audio_frame_pacer: fractional-rate frame pacer with drift correction
// Converts elapsed time per tick into whole stereo frames and reports how
// many sample values to emit and how many to pull from the source buffer.
// ----------------------------------------------------------------------------
// Each input transaction is one pacing tick. The block accepts one tick per
// clock cycle unless results held up at the output have filled the queue,
// and returns exactly one result transaction per tick, in order. The rate
// is set by the accumulator in the back end, whose fraction carry,
// saturating pending count and cap compare are all combinational ahead of
// its state registers; all divisions by one second happen ahead of it in a
// 7-stage pipeline. Writing sample_rate clears the fraction and pending frame
// count; write the registers only while no tick is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_frame_pacer #(
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // tick input
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [71:0]  s_tdata,   // [39:0] elapsed_ns, [55:40] max_values,
                                         // [71:56] buffered_values
    // result output
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [39:0]       m_tdata,   // [15:0] values_due, [32:16] source_values,
                                         // [39:33] zero
    // register writes
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_idx,
    input  wire logic [17:0]  cfg_wdata
);

    // configuration registers
    logic [afp_pkg::RATE_W-1:0] rate_reg;
    logic [afp_pkg::VAL_W-1:0]  target_reg;
    logic [afp_pkg::VAL_W-1:0]  hyst_reg;
    logic                       rate_wr;

    // front -> queue -> back
    logic           fr_valid, fr_ready;
    afp_pkg::item_t fr_item;
    logic           q_valid, q_ready;
    afp_pkg::item_t q_item;

    logic [afp_pkg::VAL_W-1:0] values_due;
    logic [afp_pkg::SRC_W-1:0] source_values;

    assign rate_wr = cfg_we && (cfg_idx == afp_pkg::CFG_SAMPLE_RATE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg   <= afp_pkg::RATE_RESET;
            target_reg <= '0;
            hyst_reg   <= '0;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                afp_pkg::CFG_SAMPLE_RATE: rate_reg   <= cfg_wdata;
                afp_pkg::CFG_TARGET:      target_reg <= cfg_wdata[afp_pkg::VAL_W-1:0];
                afp_pkg::CFG_HYSTERESIS:  hyst_reg   <= cfg_wdata[afp_pkg::VAL_W-1:0];
                default: ;  // unused index, write ignored
            endcase
        end
    end

    // front: time split, rate scaling, buffer classification
    afp_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .in_valid          (s_tvalid),
        .in_ready          (s_tready),
        .elapsed_ns        (s_tdata[39:0]),
        .max_values        (s_tdata[55:40]),
        .buffered_values   (s_tdata[71:56]),
        .sample_rate       (rate_reg),
        .target_values     (target_reg),
        .hysteresis_values (hyst_reg),
        .item_valid        (fr_valid),
        .item              (fr_item),
        .item_ready        (fr_ready)
    );

    // queue lets the front keep going while results wait downstream
    afp_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_item   (fr_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    // back: accumulator state and result register
    afp_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .clear         (rate_wr),
        .item_valid    (q_valid),
        .item_ready    (q_ready),
        .item          (q_item),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .values_due    (values_due),
        .source_values (source_values)
    );

    assign m_tdata = {7'd0, source_values, values_due};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // only whole frames go out
    a_due_even: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == 1'b0))
        else $error("values_due is odd");

    // drift correction moves the source count by at most one frame
    a_src_band: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[32:16] == {1'b0, m_tdata[15:0]}) ||
                      (m_tdata[32:16] == {1'b0, m_tdata[15:0]} + 17'd2) ||
                      (m_tdata[32:16] + 17'd2 == {1'b0, m_tdata[15:0]})))
        else $error("source_values out of band");

    // input stalls only when a result is held up at the output
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

endmodule

`default_nettype wire

/* hdl/afp_front.sv */
// ----------------------------------------------------------------------------
// afp_front: tick pre-processing pipeline
// Splits elapsed time into seconds and remainder, scales by the sample rate
// and splits the sub-second product into whole frames and a fraction.
// Also classifies the buffer fill against the drift band.
// ----------------------------------------------------------------------------
`default_nettype none

module afp_front (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [afp_pkg::NS_W-1:0]     elapsed_ns,
    input  wire logic [afp_pkg::VAL_W-1:0]    max_values,
    input  wire logic [afp_pkg::VAL_W-1:0]    buffered_values,
    input  wire logic [afp_pkg::RATE_W-1:0]   sample_rate,
    input  wire logic [afp_pkg::VAL_W-1:0]    target_values,
    input  wire logic [afp_pkg::VAL_W-1:0]    hysteresis_values,
    output logic                              item_valid,
    output afp_pkg::item_t                    item,
    input  wire logic                         item_ready
);

    localparam int NSTAGE = 7;

    typedef struct packed {
        logic [afp_pkg::FRAMES_W-1:0] max_frames;
        logic                         over;
        logic                         under;
    } side_t;

    logic [NSTAGE-1:0] valid_reg;
    logic              en;
    side_t             side_reg [NSTAGE-1];
    side_t             side_in;

    // stage 1
    logic [afp_pkg::NS_W-1:0]   el1_reg;
    logic [afp_pkg::SECS_W-1:0] q1_reg;
    logic [51:0]                prod1;
    // stage 2
    logic [afp_pkg::NS_W-1:0]   el2_reg;
    logic [afp_pkg::SECS_W-1:0] q2_reg;
    logic [afp_pkg::NS_W-1:0]   pp1_reg;
    logic [40:0]                pp1_full;
    // stage 3
    logic [afp_pkg::SECS_W-1:0] secs3_reg;
    logic [afp_pkg::FRAC_W-1:0] rem3_reg;
    logic [afp_pkg::NS_W-1:0]   r1;
    logic                       ge1;
    // stage 4
    logic [47:0]                p4_reg;
    logic [afp_pkg::BASE_W-1:0] sr4_reg;
    // stage 5
    logic [47:0]                p5_reg;
    logic [afp_pkg::BASE_W-1:0] sr5_reg;
    logic [afp_pkg::PQ_W-1:0]   q5_reg;
    logic [59:0]                prod2;
    // stage 6
    logic [47:0]                p6_reg;
    logic [afp_pkg::BASE_W-1:0] sr6_reg;
    logic [afp_pkg::PQ_W-1:0]   q6_reg;
    logic [47:0]                pp2_reg;
    // stage 7
    logic [47:0]                r2;
    logic                       ge2;
    logic [afp_pkg::PQ_W-1:0]   pq;
    afp_pkg::item_t             item_reg;

    // whole pipeline moves together; it holds only while the queue is full
    assign en       = !valid_reg[NSTAGE-1] || item_ready;
    assign in_ready = en;

    always_comb begin
        side_in.max_frames = max_values[afp_pkg::VAL_W-1:1];
        side_in.over  = {1'b0, buffered_values} >
                        ({1'b0, target_values} + {1'b0, hysteresis_values});
        side_in.under = ({1'b0, buffered_values} + {1'b0, hysteresis_values}) <
                        {1'b0, target_values};
    end

    assign prod1    = 52'(elapsed_ns[afp_pkg::NS_W-1:afp_pkg::HI_SHIFT]) * 52'(afp_pkg::RECIP);
    assign pp1_full = 41'(q1_reg) * 41'(afp_pkg::NS_PER_SEC);
    assign r1       = el2_reg - pp1_reg;
    assign ge1      = r1[30:0] >= 31'(afp_pkg::NS_PER_SEC);
    assign prod2    = 60'(p4_reg[47:afp_pkg::HI_SHIFT]) * 60'(afp_pkg::RECIP);
    assign r2       = p6_reg - pp2_reg;
    assign ge2      = r2[30:0] >= 31'(afp_pkg::NS_PER_SEC);
    assign pq       = q6_reg + afp_pkg::PQ_W'(ge2);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[NSTAGE-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_in;
            for (int i = 1; i < NSTAGE - 1; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
            // stage 1: seconds estimate
            el1_reg <= elapsed_ns;
            q1_reg  <= prod1[afp_pkg::RECIP_SHIFT +: afp_pkg::SECS_W];
            // stage 2
            el2_reg <= el1_reg;
            q2_reg  <= q1_reg;
            pp1_reg <= pp1_full[afp_pkg::NS_W-1:0];
            // stage 3: one correction step
            secs3_reg <= ge1 ? q2_reg + afp_pkg::SECS_W'(1) : q2_reg;
            rem3_reg  <= ge1 ? afp_pkg::FRAC_W'(r1 - afp_pkg::NS_W'(afp_pkg::NS_PER_SEC))
                             : r1[afp_pkg::FRAC_W-1:0];
            // stage 4: scale by rate
            p4_reg  <= 48'(rem3_reg) * 48'(sample_rate);
            sr4_reg <= afp_pkg::BASE_W'(afp_pkg::BASE_W'(secs3_reg) *
                                        afp_pkg::BASE_W'(sample_rate));
            // stage 5: frames estimate
            p5_reg  <= p4_reg;
            sr5_reg <= sr4_reg;
            q5_reg  <= prod2[afp_pkg::RECIP_SHIFT +: afp_pkg::PQ_W];
            // stage 6
            p6_reg  <= p5_reg;
            sr6_reg <= sr5_reg;
            q6_reg  <= q5_reg;
            pp2_reg <= 48'(q5_reg) * 48'(afp_pkg::NS_PER_SEC);
            // stage 7: correction, assemble item
            item_reg.base       <= sr6_reg + afp_pkg::BASE_W'(pq);
            item_reg.frac_add   <= ge2 ? afp_pkg::FRAC_W'(r2 - 48'(afp_pkg::NS_PER_SEC))
                                       : r2[afp_pkg::FRAC_W-1:0];
            item_reg.max_frames <= side_reg[NSTAGE-2].max_frames;
            item_reg.over       <= side_reg[NSTAGE-2].over;
            item_reg.under      <= side_reg[NSTAGE-2].under;
        end
    end

    assign item_valid = valid_reg[NSTAGE-1];
    assign item       = item_reg;

endmodule

`default_nettype wire

/* hdl/afp_fifo.sv */
// ----------------------------------------------------------------------------
// afp_fifo: short item queue
// Decouples the pre-processing pipeline from the accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module afp_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire afp_pkg::item_t in_item,
    output logic                out_valid,
    input  wire logic           out_ready,
    output afp_pkg::item_t      out_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    afp_pkg::item_t mem [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic           push, pop;

    assign in_ready  = count_reg != CW'(DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

/* hdl/afp_back.sv */
// ----------------------------------------------------------------------------
// afp_back: frame accumulator and result register
// Carries the fraction, saturates the pending count, releases frames up to
// the cap and forms the drift-corrected source count.
// ----------------------------------------------------------------------------
`default_nettype none

module afp_back (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           clear,
    input  wire logic                           item_valid,
    output logic                                item_ready,
    input  wire afp_pkg::item_t                 item,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [afp_pkg::VAL_W-1:0]           values_due,
    output logic [afp_pkg::SRC_W-1:0]           source_values
);

    logic [afp_pkg::FRAC_W-1:0]   frac_reg, frac_next;
    logic [afp_pkg::PEND_W-1:0]   pend_reg, pend_next;
    logic                         out_valid_reg;
    logic [afp_pkg::VAL_W-1:0]    due_reg, due_next;
    logic [afp_pkg::SRC_W-1:0]    src_reg, src_next;

    logic [afp_pkg::FRAC_W:0]     fsum;
    logic                         carry;
    logic [afp_pkg::PEND_W:0]     total;
    logic [afp_pkg::PEND_W-1:0]   total_sat;
    logic [afp_pkg::FRAMES_W-1:0] frames;
    logic                         pop;

    assign item_ready = !out_valid_reg || out_ready;
    assign pop        = item_valid && item_ready;

    always_comb begin
        fsum      = {1'b0, frac_reg} + {1'b0, item.frac_add};
        carry     = fsum >= (afp_pkg::FRAC_W + 1)'(afp_pkg::NS_PER_SEC);
        frac_next = carry ? afp_pkg::FRAC_W'(fsum - (afp_pkg::FRAC_W + 1)'(afp_pkg::NS_PER_SEC))
                          : fsum[afp_pkg::FRAC_W-1:0];
        total     = {1'b0, pend_reg} + (afp_pkg::PEND_W + 1)'(item.base)
                    + (afp_pkg::PEND_W + 1)'(carry);
        total_sat = total[afp_pkg::PEND_W] ? '1 : total[afp_pkg::PEND_W-1:0];
        frames    = (total_sat < afp_pkg::PEND_W'(item.max_frames))
                    ? total_sat[afp_pkg::FRAMES_W-1:0] : item.max_frames;
        pend_next = total_sat - afp_pkg::PEND_W'(frames);
        due_next  = {frames, 1'b0};
        if (frames == '0) begin
            src_next = '0;
        end else if (item.over) begin
            src_next = afp_pkg::SRC_W'(due_next) + afp_pkg::SRC_W'(2);
        end else if (item.under && (frames >= afp_pkg::FRAMES_W'(2))) begin
            src_next = afp_pkg::SRC_W'(due_next) - afp_pkg::SRC_W'(2);
        end else begin
            src_next = afp_pkg::SRC_W'(due_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frac_reg      <= '0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (clear) begin
                frac_reg <= '0;
                pend_reg <= '0;
            end else if (pop) begin
                frac_reg <= frac_next;
                pend_reg <= pend_next;
            end
            if (item_ready) begin
                out_valid_reg <= item_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            due_reg <= due_next;
            src_reg <= src_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign values_due    = due_reg;
    assign source_values = src_reg;

endmodule

`default_nettype wire

/* tb/audio_frame_pacer_checker.sv */
// ----------------------------------------------------------------------------
// audio_frame_pacer_checker: result predictor and scoreboard
// Watches the tick, result and register channels. It keeps its own copy of
// the pacing state and compares every result transaction in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module audio_frame_pacer_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [71:0] s_tdata,   // [39:0] elapsed_ns, [55:40] max_values,
                                        // [71:56] buffered_values
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [39:0] m_tdata,   // [15:0] values_due, [32:16] source_values
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_idx,
    input  wire logic [17:0] cfg_wdata,
    output int               mismatches,
    output int               results_owed
);

    localparam logic [63:0] NS_PER_SECOND = 64'd1000000000;
    localparam logic [63:0] PENDING_CEIL  = 64'hFFFF_FFFF;

    typedef struct packed {
        logic [15:0] values_due;
        logic [16:0] source_values;
    } pace_result_t;

    pace_result_t owed_results[$];

    logic [17:0] rate;
    logic [15:0] target;
    logic [15:0] hyst;
    logic [29:0] frame_frac;
    logic [31:0] frames_pending;

    // Advances the pacing state by one tick and returns what it must report.
    function automatic pace_result_t pace_tick(input logic [39:0] elapsed,
                                               input logic [15:0] max_values,
                                               input logic [15:0] buffered);
        logic [63:0]  whole_s;
        logic [63:0]  sub_ns;
        logic [63:0]  numer;
        logic [63:0]  total;
        logic [63:0]  cap;
        logic [63:0]  frames;
        logic [63:0]  due;
        logic [63:0]  buf64;
        logic [63:0]  tgt64;
        logic [63:0]  hys64;
        logic [63:0]  src;
        pace_result_t res;
        whole_s = {24'd0, elapsed} / NS_PER_SECOND;
        sub_ns  = {24'd0, elapsed} % NS_PER_SECOND;
        numer   = {34'd0, frame_frac} + sub_ns * {46'd0, rate};
        total   = {32'd0, frames_pending} + whole_s * {46'd0, rate} + numer / NS_PER_SECOND;
        if (total > PENDING_CEIL) begin
            total = PENDING_CEIL;
        end
        frame_frac = 30'(numer % NS_PER_SECOND);

        cap    = {48'd0, max_values} >> 1;
        frames = (total < cap) ? total : cap;
        frames_pending = 32'(total - frames);
        due = frames * 2;

        buf64 = {48'd0, buffered};
        tgt64 = {48'd0, target};
        hys64 = {48'd0, hyst};
        if (due == 0) begin
            src = 0;
        end else if (buf64 > tgt64 + hys64) begin
            src = due + 2;
        end else if (buf64 + hys64 < tgt64 && due >= 4) begin
            src = due - 2;
        end else begin
            src = due;
        end
        res.values_due    = due[15:0];
        res.source_values = src[16:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        pace_result_t want;
        if (!aresetn) begin
            rate           = afp_pkg::RATE_RESET;
            target         = '0;
            hyst           = '0;
            frame_frac     = '0;
            frames_pending = '0;
            owed_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (owed_results.size() == 0) begin
                    $error("result transaction with no tick outstanding: tdata %h", m_tdata);
                    mismatches++;
                end else begin
                    want = owed_results.pop_front();
                    if (m_tdata[15:0] !== want.values_due) begin
                        $error("values_due: expected %0d, got %0d",
                               want.values_due, m_tdata[15:0]);
                        mismatches++;
                    end
                    if (m_tdata[32:16] !== want.source_values) begin
                        $error("source_values: expected %0d, got %0d",
                               want.source_values, m_tdata[32:16]);
                        mismatches++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                owed_results.push_back(pace_tick(s_tdata[39:0], s_tdata[55:40],
                                                 s_tdata[71:56]));
            end
            if (cfg_we) begin
                case (cfg_idx)
                    afp_pkg::CFG_SAMPLE_RATE: begin
                        rate           = cfg_wdata;
                        frame_frac     = '0;
                        frames_pending = '0;
                    end
                    afp_pkg::CFG_TARGET:     target = cfg_wdata[15:0];
                    afp_pkg::CFG_HYSTERESIS: hyst   = cfg_wdata[15:0];
                    default: ;
                endcase
            end
        end
        results_owed = owed_results.size();
    end

endmodule

/* tb/audio_frame_pacer_tb.sv */
// ----------------------------------------------------------------------------
// audio_frame_pacer_tb: top-level testbench for the audio frame pacer
// Drives pacing ticks and register writes through several rate and drift
// settings under varying backpressure; a checker alongside scores results.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module audio_frame_pacer_tb;

    // unmapped register slot, writes there must change nothing
    localparam logic [1:0] CFG_UNMAPPED = 2'd3;

    localparam logic [39:0] ELAPSED_MAX = 40'hFF_FFFF_FFFF;
    localparam int          QUIET_LIMIT = 2000;  // cycles with no transaction
    localparam int          DRAIN_HOLD  = 20;    // exceeds the pipeline latency
    localparam int          ITEMS_PER_PHASE = 112;
    localparam int          PHASES      = 8;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata   = '0;  // [39:0] elapsed_ns, [55:40] max_values,
                                  // [71:56] buffered_values
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;         // [15:0] values_due, [32:16] source_values
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_idx   = '0;
    logic [17:0] cfg_wdata = '0;

    int mismatches;
    int results_owed;

    // idle percentages for the sender and the receiver, set per phase
    int gap_pct   = 0;
    int stall_pct = 0;

    // mirror of the drift registers, used to aim buffered_values near the band
    int cur_target = 0;
    int cur_hyst   = 0;

    int quiet_cycles = 0;

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    audio_frame_pacer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata)
    );

    audio_frame_pacer_checker i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_we       (cfg_we),
        .cfg_idx      (cfg_idx),
        .cfg_wdata    (cfg_wdata),
        .mismatches   (mismatches),
        .results_owed (results_owed)
    );

    // Receiver backpressure: a fresh coin per cycle, changed on the falling edge.
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    // Watchdog: any stretch without a transaction on either stream that runs
    // this long means the block has hung.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[audio_frame_pacer] ERROR");
                $finish;
            end
        end
    end

    // One register write. Starts and ends on a falling edge; the enable is
    // dropped before the final wait so back-to-back calls never assign cfg_we
    // twice in one time step.
    task automatic write_reg(input logic [1:0] idx, input logic [17:0] data);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
        if (idx == afp_pkg::CFG_TARGET) begin
            cur_target = int'(data[15:0]);
        end else if (idx == afp_pkg::CFG_HYSTERESIS) begin
            cur_hyst = int'(data[15:0]);
        end
    endtask

    // One tick transaction. Optional idle cycles first, then hold valid until
    // the handshake completes at a rising edge. Returns on a falling edge with
    // tvalid still high, so the next tick can follow without a bubble.
    task automatic send_tick(input logic [39:0] elapsed, input logic [15:0] max_values,
                             input logic [15:0] buffered);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {buffered, max_values, elapsed};
        do begin
            @(posedge aclk);
        end while (!s_tready);
        @(negedge aclk);
    endtask

    // Drop valid and wait for every outstanding result. Each tick yields a
    // result, so an empty scoreboard means the block is idle.
    task automatic drain;
        s_tvalid <= 1'b0;
        while (results_owed != 0) begin
            @(negedge aclk);
        end
    endtask

    // Random tick, weighted toward realistic audio periods and toward buffer
    // fills close to the drift band edges.
    task automatic random_tick;
        int          pick;
        int          fill;
        logic [39:0] elapsed;
        logic [39:0] secs;
        logic [15:0] max_values;
        logic [15:0] buffered;
        pick = $urandom_range(99);
        if (pick < 55) begin
            elapsed = 40'($urandom_range(2_000_000));         // ~ms audio periods
        end else if (pick < 75) begin
            elapsed = 40'($urandom_range(999_999_999));       // sub-second
        end else if (pick < 85) begin
            secs    = 40'($urandom_range(1099));              // near whole seconds
            elapsed = secs * 40'd1_000_000_000 + 40'($urandom_range(2));
        end else begin
            elapsed = 40'({$urandom(), $urandom()});          // full 40-bit range
        end

        pick = $urandom_range(99);
        if (pick < 40) begin
            max_values = 16'($urandom());
        end else if (pick < 70) begin
            max_values = 16'($urandom_range(16));
        end else if (pick < 90) begin
            max_values = 16'($urandom_range(512));
        end else begin
            case ($urandom_range(2))
                0:       max_values = 16'hFFFF;
                1:       max_values = 16'hFFFE;
                default: max_values = 16'h0000;
            endcase
        end

        if ($urandom_range(1) == 0) begin
            fill = cur_target + $urandom_range(2 * cur_hyst + 6) - cur_hyst - 3;
            if (fill < 0) begin
                fill = 0;
            end else if (fill > 65535) begin
                fill = 65535;
            end
            buffered = fill[15:0];
        end else begin
            buffered = 16'($urandom());
        end
        send_tick(elapsed, max_values, buffered);
    endtask

    initial begin
        int          mode;
        logic [17:0] rate;
        logic [15:0] tgt;
        logic [15:0] hys;
        bit          with_rate;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // ---- directed: reset defaults (48 kHz, no drift band) ----
        send_tick(40'd0, 16'd0, 16'd0);                       // nothing owed
        send_tick(40'd1_000_000, 16'hFFFF, 16'hFFFF);         // 48 frames, odd cap, over-full
        send_tick(ELAPSED_MAX, 16'd0, 16'd0);                 // pile up, nothing released
        send_tick(40'd0, 16'hFFFF, 16'd0);                    // release at the cap
        send_tick(40'd0, 16'd1, 16'hFFFF);                    // odd cap of one frees nothing
        send_tick(40'd999_999_999, 16'd2, 16'd1);             // fraction carry, single frame
        drain();

        // ---- directed: drift band 1000 +/- 10, pending carried over ----
        write_reg(afp_pkg::CFG_TARGET, 18'd1000);
        write_reg(afp_pkg::CFG_HYSTERESIS, 18'd10);
        write_reg(CFG_UNMAPPED, 18'h3FFFF);                   // must be ignored
        send_tick(40'd0, 16'd2, 16'd0);                       // under-full but only one frame
        send_tick(40'd0, 16'd4, 16'd0);                       // under-full, trims by two
        send_tick(40'd0, 16'd8, 16'd990);                     // on the lower band edge
        send_tick(40'd0, 16'd8, 16'd1010);                    // on the upper band edge
        send_tick(40'd0, 16'd8, 16'd1011);                    // just above the band
        drain();

        // ---- directed: top rate, widest band, pending count saturates ----
        write_reg(afp_pkg::CFG_SAMPLE_RATE, 18'h3FFFF);
        write_reg(afp_pkg::CFG_TARGET, 18'hFFFF);
        write_reg(afp_pkg::CFG_HYSTERESIS, 18'hFFFF);
        repeat (15) send_tick(ELAPSED_MAX, 16'd0, 16'hFFFF);
        send_tick(40'd0, 16'hFFFF, 16'hFFFF);                 // band sums must not wrap
        drain();

        // ---- directed: zero rate accumulates nothing ----
        write_reg(afp_pkg::CFG_SAMPLE_RATE, 18'd0);
        send_tick(ELAPSED_MAX, 16'hFFFF, 16'd0);
        drain();

        // ---- random phases: each with its own rate, band and idle pattern ----
        for (int p = 0; p < PHASES; p++) begin
            with_rate = 1'b1;
            case (p)
                0: begin rate = 18'd1;      tgt = 16'd0;     hys = 16'd0;     end
                1: begin rate = 18'd192000; tgt = 16'hFFFF;  hys = 16'hFFFF;  end
                2: begin
                    rate = 18'd44100;
                    tgt  = 16'($urandom());
                    hys  = 16'($urandom_range(64));
                end
                3: begin
                    // keep rate and accumulated frames from the previous phase
                    with_rate = 1'b0;
                    rate = '0; tgt = 16'd2048; hys = 16'd64;
                end
                4: begin rate = 18'h3FFFF;  tgt = 16'd0;     hys = 16'hFFFF;  end
                5: begin rate = 18'd0;      tgt = 16'hFFFF;  hys = 16'd0;     end
                6: begin
                    rate = 18'($urandom_range(192000, 1));
                    tgt  = 16'($urandom());
                    hys  = 16'($urandom_range(16));
                end
                default: begin
                    rate = 18'd48000;
                    tgt  = 16'($urandom());
                    hys  = 16'($urandom());
                end
            endcase
            if (with_rate) begin
                write_reg(afp_pkg::CFG_SAMPLE_RATE, rate);
            end
            write_reg(afp_pkg::CFG_TARGET, {2'b00, tgt});
            write_reg(afp_pkg::CFG_HYSTERESIS, {2'b00, hys});

            mode = p % 4;
            case (mode)
                0:       begin gap_pct = 0;  stall_pct = 0;  end
                1:       begin gap_pct = 47; stall_pct = 0;  end
                2:       begin gap_pct = 0;  stall_pct = 47; end
                default: begin gap_pct = 15; stall_pct = 15; end
            endcase

            repeat (ITEMS_PER_PHASE) random_tick();
            drain();
        end

        gap_pct   = 0;
        stall_pct = 0;
        repeat (DRAIN_HOLD) @(posedge aclk);

        if (mismatches == 0 && results_owed == 0) begin
            $display("[audio_frame_pacer] OK");
        end else begin
            $display("[audio_frame_pacer] ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/afp_pkg.sv
hdl/afp_front.sv
hdl/afp_fifo.sv
hdl/afp_back.sv
hdl/audio_frame_pacer.sv
tb/audio_frame_pacer_checker.sv
tb/audio_frame_pacer_tb.sv
